>>> rtl/frma_pkg.sv
// Shared types, constants and the sequencer program for the frame rate meter.
// Used by frame_rate_meter_avg; depends on nothing else.

package frma_pkg;

    // Field widths of the stream items and the configuration register.
    localparam int TS_W     = 32;
    localparam int WIN_W    = 16;
    localparam int FPS_W    = 26;
    localparam int AVG_W    = 17;
    localparam int FCNT_W   = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // Reset values and fixed arithmetic constants.
    localparam logic [WIN_W-1:0]  WINDOW_MS_RESET = 16'd500;
    localparam int                HISTORY_DEPTH_DEFAULT = 8;
    localparam logic [17:0]       FPS_SCALE = 18'd256000;   // 1000 ms/s in Q.8
    localparam logic [FCNT_W-1:0] FCNT_MAX = 16'hFFFF;
    localparam logic [AVG_W-1:0]  AVG_MAX = 17'h1FFFF;

    // Shared divider: dividend, divisor and step counter widths.
    localparam int DIV_W  = 34;
    localparam int DVS_W  = 32;
    localparam int DCNT_W = $clog2(DIV_W);

    // Sequencer step index.
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    // Datapath operations selected by one control word.
    typedef enum logic [2:0] {
        OP_IDLE,      // wait for an input transfer
        OP_CHECK,     // compare elapsed time, fetch the oldest history entry
        OP_LOAD_FPS,  // load divider with frame count scaled over elapsed time
        OP_DIV,       // one restoring division step
        OP_STORE,     // write the sample into the ring, update running sum
        OP_LOAD_AVG,  // load divider with the rounded average division
        OP_EMIT       // present the result and restart the window
    } op_t;

    // Jump conditions; when true the sequencer goes to the target step.
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_ACCEPT,
        C_SHORT,
        C_DIV_MORE,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // The program. The last step falls through to step zero on wrap.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            3'd0: w = '{op: OP_IDLE,     cond: C_NO_ACCEPT, target: 3'd0};
            3'd1: w = '{op: OP_CHECK,    cond: C_SHORT,     target: 3'd0};
            3'd2: w = '{op: OP_LOAD_FPS, cond: C_NEVER,     target: 3'd0};
            3'd3: w = '{op: OP_DIV,      cond: C_DIV_MORE,  target: 3'd3};
            3'd4: w = '{op: OP_STORE,    cond: C_NEVER,     target: 3'd0};
            3'd5: w = '{op: OP_LOAD_AVG, cond: C_NEVER,     target: 3'd0};
            3'd6: w = '{op: OP_DIV,      cond: C_DIV_MORE,  target: 3'd6};
            3'd7: w = '{op: OP_EMIT,     cond: C_OUT_FULL,  target: 3'd7};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/frame_rate_meter_avg.sv
// Frame rate meter with a moving average over a ring of window samples.
// Depends on frma_pkg for widths, constants and the sequencer program.

// Each input transfer is one finished frame with its millisecond timestamp.
// A frame that does not close the measurement window goes back to idle after
// the check. A frame that closes it runs a shared restoring divider twice
// (34 steps for the window rate, 34 for the average) at one quotient bit per
// cycle, with six sequencer steps around it. The block accepts no new
// frame until the result is loaded into the output register; the output
// register then holds it independently of the input side. A window_ms of 0 is
// treated as 1. The average is kept as a running sum of the positive entries,
// so no pass over the history is needed.

module frame_rate_meter_avg #(
    parameter int HISTORY_DEPTH = frma_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: window length in milliseconds.
    input  logic                           cfg_wr_en,
    input  logic [frma_pkg::WIN_W-1:0]     cfg_wr_data,
    // Input stream. tdata: timestamp_ms[31:0].
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [frma_pkg::S_TDATA_W-1:0] s_tdata,
    // Output stream. tdata: avg_fps[16:0], window_fps[42:17], changed[43],
    // zero padding[47:44].
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [frma_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = frma_pkg::FPS_W + $clog2(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    // Sequencer.
    frma_pkg::step_t  step_reg, step_next;
    frma_pkg::ucode_t uword;
    logic             cond_true;

    // Configuration and window state.
    logic [frma_pkg::WIN_W-1:0]  window_ms_reg;
    logic [frma_pkg::FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic [frma_pkg::TS_W-1:0]   wstart_reg, wstart_next;
    logic [frma_pkg::TS_W-1:0]   now_reg, now_next;
    logic [frma_pkg::TS_W-1:0]   elapsed_reg, elapsed_next;
    logic [frma_pkg::TS_W-1:0]   limit;

    // History ring.
    logic [frma_pkg::FPS_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [frma_pkg::FPS_W-1:0] hist_rd_reg;
    logic [HISTORY_DEPTH-1:0]   hist_vld_reg, hist_vld_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           npos_reg, npos_next;

    // Divider.
    logic [frma_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [frma_pkg::DVS_W:0]    rem_reg, rem_next;
    logic [frma_pkg::DVS_W-1:0]  dvs_reg, dvs_next;
    logic [frma_pkg::DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [frma_pkg::DVS_W:0]    rem_shift;
    logic [frma_pkg::DVS_W+1:0]  rem_trial;

    // Sample, average and output.
    logic [frma_pkg::FPS_W-1:0] fps_reg, fps_next;
    logic [frma_pkg::FPS_W-1:0] fps_sat;
    logic [frma_pkg::AVG_W-1:0] avg_val;
    logic [frma_pkg::AVG_W-1:0] last_avg_reg, last_avg_next;
    logic                       shown_reg, shown_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [frma_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                       in_xfer;
    logic                       out_full;
    logic                       changed;

    // Current control word and handshake status.
    assign uword    = frma_pkg::ucode_rom(step_reg);
    assign s_tready = (uword.op == frma_pkg::OP_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_full = m_tvalid_reg && !m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign limit    = (window_ms_reg == '0) ? frma_pkg::TS_W'(1)
                                            : frma_pkg::TS_W'(window_ms_reg);

    // Jump condition decode.
    always_comb begin
        unique case (uword.cond)
            frma_pkg::C_NEVER:     cond_true = 1'b0;
            frma_pkg::C_NO_ACCEPT: cond_true = !in_xfer;
            frma_pkg::C_SHORT:     cond_true = (elapsed_reg < limit);
            frma_pkg::C_DIV_MORE:  cond_true = (dcnt_reg != '0);
            frma_pkg::C_OUT_FULL:  cond_true = out_full;
            default:               cond_true = 1'b0;
        endcase
    end

    // Next step: jump target when the condition holds, else the following step.
    always_comb begin
        step_next = cond_true ? uword.target : step_reg + frma_pkg::step_t'(1);
    end

    // One restoring division step.
    always_comb begin
        rem_shift = {rem_reg[frma_pkg::DVS_W-1:0], quo_reg[frma_pkg::DIV_W-1]};
        rem_trial = {1'b0, rem_shift} - {2'b00, dvs_reg};
    end

    // Saturated window rate and clamped average from the divider quotient.
    always_comb begin
        fps_sat = (quo_reg[frma_pkg::DIV_W-1:frma_pkg::FPS_W] != '0)
                ? '1 : quo_reg[frma_pkg::FPS_W-1:0];
        if (npos_reg == '0) begin
            avg_val = '0;
        end else if (quo_reg[frma_pkg::DIV_W-1:frma_pkg::AVG_W] != '0) begin
            avg_val = frma_pkg::AVG_MAX;
        end else begin
            avg_val = quo_reg[frma_pkg::AVG_W-1:0];
        end
        changed = !shown_reg || (avg_val != last_avg_reg);
    end

    // Datapath driven by the current operation.
    always_comb begin
        fcnt_next     = fcnt_reg;
        wstart_next   = wstart_reg;
        now_next      = now_reg;
        elapsed_next  = elapsed_reg;
        hist_vld_next = hist_vld_reg;
        ptr_next      = ptr_reg;
        sum_next      = sum_reg;
        npos_next     = npos_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        dcnt_next     = dcnt_reg;
        fps_next      = fps_reg;
        last_avg_next = last_avg_reg;
        shown_next    = shown_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (uword.op)
            frma_pkg::OP_IDLE: begin
                if (in_xfer) begin
                    now_next     = s_tdata[frma_pkg::TS_W-1:0];
                    elapsed_next = s_tdata[frma_pkg::TS_W-1:0] - wstart_reg;
                    if (fcnt_reg != frma_pkg::FCNT_MAX) begin
                        fcnt_next = fcnt_reg + frma_pkg::FCNT_W'(1);
                    end
                end
            end
            frma_pkg::OP_CHECK: begin
                // Oldest entry is read into hist_rd_reg by the memory block.
            end
            frma_pkg::OP_LOAD_FPS: begin
                quo_next  = frma_pkg::DIV_W'(fcnt_reg * frma_pkg::FPS_SCALE);
                rem_next  = '0;
                dvs_next  = elapsed_reg;
                dcnt_next = frma_pkg::DCNT_W'(frma_pkg::DIV_W - 1);
            end
            frma_pkg::OP_DIV: begin
                if (!rem_trial[frma_pkg::DVS_W+1]) begin
                    rem_next = rem_trial[frma_pkg::DVS_W:0];
                    quo_next = {quo_reg[frma_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[frma_pkg::DIV_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - frma_pkg::DCNT_W'(1);
            end
            frma_pkg::OP_STORE: begin
                // Replace the oldest entry in the running sum and positive count.
                fps_next = fps_sat;
                sum_next = sum_reg
                         - (hist_vld_reg[ptr_reg] ? SUM_W'(hist_rd_reg) : '0)
                         + SUM_W'(fps_sat);
                npos_next = npos_reg
                          - (hist_vld_reg[ptr_reg] ? CNT_W'(1) : '0)
                          + ((fps_sat != '0) ? CNT_W'(1) : '0);
                hist_vld_next[ptr_reg] = (fps_sat != '0);
                ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
            end
            frma_pkg::OP_LOAD_AVG: begin
                // floor((S + 128 n) / (256 n)) rounds the Q.8 mean half up.
                quo_next  = frma_pkg::DIV_W'(sum_reg)
                          + (frma_pkg::DIV_W'(npos_reg) << 7);
                rem_next  = '0;
                dvs_next  = frma_pkg::DVS_W'(npos_reg) << 8;
                dcnt_next = frma_pkg::DCNT_W'(frma_pkg::DIV_W - 1);
            end
            frma_pkg::OP_EMIT: begin
                if (!out_full) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, changed, fps_reg, avg_val};
                    last_avg_next = avg_val;
                    shown_next    = 1'b1;
                    fcnt_next     = '0;
                    wstart_next   = now_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and window registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            window_ms_reg <= frma_pkg::WINDOW_MS_RESET;
            fcnt_reg      <= '0;
            wstart_reg    <= '0;
            hist_vld_reg  <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            npos_reg      <= '0;
            last_avg_reg  <= '0;
            shown_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            dcnt_reg      <= '0;
        end else begin
            step_reg      <= step_next;
            if (cfg_wr_en) begin
                window_ms_reg <= cfg_wr_data;
            end
            fcnt_reg      <= fcnt_next;
            wstart_reg    <= wstart_next;
            hist_vld_reg  <= hist_vld_next;
            ptr_reg       <= ptr_next;
            sum_reg       <= sum_next;
            npos_reg      <= npos_next;
            last_avg_reg  <= last_avg_next;
            shown_reg     <= shown_next;
            m_tvalid_reg  <= m_tvalid_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        fps_reg     <= fps_next;
        m_tdata_reg <= m_tdata_next;
    end

    // History memory: read the oldest entry while checking, write the new sample.
    always_ff @(posedge aclk) begin
        if (uword.op == frma_pkg::OP_CHECK) begin
            hist_rd_reg <= hist_mem[ptr_reg];
        end
        if (uword.op == frma_pkg::OP_STORE) begin
            hist_mem[ptr_reg] <= fps_sat;
        end
    end

endmodule
